// ===== rtl/tec_seq_pkg.sv =====
// Shared types and constants of the thermoelectric rail and PWM sequencer.
package tec_seq_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned DelayW  = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutDataW = 48;

  // input beat kinds
  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 2'd0,
    MODE_LEVEL  = 2'd1,
    MODE_DUTY   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CONTROL_PERIOD = 3'd0,
    REG_LEVEL_HOLD     = 3'd1,
    REG_HIGH_TO_LOW    = 3'd2,
    REG_LOW_TO_HIGH    = 3'd3,
    REG_PWM_OFF        = 3'd4,
    REG_HIGH_LEVEL_ID  = 3'd5,
    REG_BAND_LOW_ID    = 3'd6,
    REG_BAND_HIGH_ID   = 3'd7
  } reg_idx_t;

  localparam logic [ValueW-1:0] RstControlPeriod = 16'd100;
  localparam logic [ValueW-1:0] RstLevelHold     = 16'd600;
  localparam logic [DelayW-1:0] RstHighToLow     = 8'd1;
  localparam logic [DelayW-1:0] RstLowToHigh     = 8'd1;
  localparam logic [ValueW-1:0] RstPwmOff        = 16'd0;
  localparam logic [LevelW-1:0] RstHighLevelId   = 8'd24;
  localparam logic [LevelW-1:0] RstBandLowId     = 8'd5;
  localparam logic [LevelW-1:0] RstBandHighId    = 8'd12;

  typedef struct packed {
    logic [ValueW-1:0] control_period;
    logic [ValueW-1:0] level_hold_steps;
    logic [DelayW-1:0] high_to_low_delay;
    logic [DelayW-1:0] low_to_high_delay;
    logic [ValueW-1:0] pwm_off_value;
    logic [LevelW-1:0] high_level_id;
    logic [LevelW-1:0] band_low_id;
    logic [LevelW-1:0] band_high_id;
  } cfg_t;

  typedef struct packed {
    logic [ValueW-1:0] period_count;
    logic [LevelW-1:0] level_request;
    logic [LevelW-1:0] level_previous;
    logic [ValueW-1:0] duty_request;
    logic [ValueW-1:0] duty_previous;
    logic [ValueW-1:0] hold_count;
    logic [DelayW-1:0] high_off_count;
    logic [DelayW-1:0] low_off_count;
    logic              rail_high;
    logic              rail_low;
    logic [ValueW-1:0] pwm_value;
  } state_t;

  typedef struct packed {
    logic              step_ran;
    logic [ValueW-1:0] duty_now;
    logic [LevelW-1:0] level_now;
    logic [ValueW-1:0] pwm_compare;
    logic              rail_low_on;
    logic              rail_high_on;
  } result_t;

endpackage

// ===== rtl/tec_seq_cfg.sv =====
// Configuration register file of the sequencer.
module tec_seq_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [tec_seq_pkg::CfgIdxW-1:0]     wr_index,
  input  logic [tec_seq_pkg::ValueW-1:0]      wr_data,
  output tec_seq_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_period    <= tec_seq_pkg::RstControlPeriod;
      cfg.level_hold_steps  <= tec_seq_pkg::RstLevelHold;
      cfg.high_to_low_delay <= tec_seq_pkg::RstHighToLow;
      cfg.low_to_high_delay <= tec_seq_pkg::RstLowToHigh;
      cfg.pwm_off_value     <= tec_seq_pkg::RstPwmOff;
      cfg.high_level_id     <= tec_seq_pkg::RstHighLevelId;
      cfg.band_low_id       <= tec_seq_pkg::RstBandLowId;
      cfg.band_high_id      <= tec_seq_pkg::RstBandHighId;
    end else if (wr_en) begin
      case (tec_seq_pkg::reg_idx_t'(wr_index))
        tec_seq_pkg::REG_CONTROL_PERIOD: cfg.control_period    <= wr_data;
        tec_seq_pkg::REG_LEVEL_HOLD:     cfg.level_hold_steps  <= wr_data;
        tec_seq_pkg::REG_HIGH_TO_LOW:    cfg.high_to_low_delay <= wr_data[7:0];
        tec_seq_pkg::REG_LOW_TO_HIGH:    cfg.low_to_high_delay <= wr_data[7:0];
        tec_seq_pkg::REG_PWM_OFF:        cfg.pwm_off_value     <= wr_data;
        tec_seq_pkg::REG_HIGH_LEVEL_ID:  cfg.high_level_id     <= wr_data[7:0];
        tec_seq_pkg::REG_BAND_LOW_ID:    cfg.band_low_id       <= wr_data[7:0];
        tec_seq_pkg::REG_BAND_HIGH_ID:   cfg.band_high_id      <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tec_seq_step.sv =====
// Per-beat update: input apply, period check and control step.
module tec_seq_step (
  input  tec_seq_pkg::cfg_t                cfg,
  input  tec_seq_pkg::state_t              cur,
  input  logic [tec_seq_pkg::ModeW-1:0]    mode,
  input  logic [tec_seq_pkg::ValueW-1:0]   value,
  output tec_seq_pkg::state_t              nxt,
  output tec_seq_pkg::result_t             res
);

  always_comb begin
    logic [tec_seq_pkg::ValueW-1:0] duty_use;
    logic                           ran;
    nxt = cur;

    case (tec_seq_pkg::mode_t'(mode))
      tec_seq_pkg::MODE_TICK: begin
        if (cur.period_count < cfg.control_period)
          nxt.period_count = cur.period_count + 16'd1;
      end
      tec_seq_pkg::MODE_LEVEL: nxt.level_request = value[7:0];
      tec_seq_pkg::MODE_DUTY:  nxt.duty_request  = value;
      default: ;
    endcase

    ran      = (nxt.period_count >= cfg.control_period);
    duty_use = nxt.duty_request;

    if (ran) begin
      nxt.period_count = '0;
      if (nxt.low_off_count != '0)  nxt.low_off_count  = nxt.low_off_count - 8'd1;
      if (nxt.high_off_count != '0) nxt.high_off_count = nxt.high_off_count - 8'd1;

      if (nxt.level_request != nxt.level_previous && nxt.hold_count != '0) begin
        nxt.hold_count = nxt.hold_count - 16'd1;
        duty_use       = nxt.duty_previous;
      end else begin
        nxt.hold_count     = cfg.level_hold_steps;
        nxt.level_previous = nxt.level_request;
        nxt.duty_previous  = duty_use;
      end

      if (nxt.level_request == cfg.high_level_id) begin
        nxt.rail_high = 1'b1;
        if (nxt.low_off_count == '0) nxt.rail_low = 1'b0;
        nxt.pwm_value      = cfg.pwm_off_value;
        nxt.high_off_count = cfg.high_to_low_delay;
      end else if (nxt.level_request >= cfg.band_low_id &&
                   nxt.level_request <= cfg.band_high_id) begin
        nxt.rail_low      = 1'b1;
        nxt.pwm_value     = duty_use;
        nxt.rail_high     = (nxt.high_off_count != '0);
        nxt.low_off_count = cfg.low_to_high_delay;
      end else begin
        nxt.rail_high     = 1'b0;
        nxt.rail_low      = 1'b0;
        nxt.pwm_value     = cfg.pwm_off_value;
        nxt.level_request = '0;
      end
    end

    res.rail_high_on = nxt.rail_high;
    res.rail_low_on  = nxt.rail_low;
    res.pwm_compare  = nxt.pwm_value;
    res.level_now    = nxt.level_request;
    res.duty_now     = nxt.duty_request;
    res.step_ran     = ran;
  end

endmodule

// ===== rtl/tec_rail_and_pwm_sequencer_core.sv =====
// Top level of the thermoelectric rail and PWM sequencer.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------------------
//  s_      | in  | s_tvalid / s_tready        | s_tdata: value; s_tuser: mode
//  m_      | out | m_tvalid / m_tready        | m_tdata: rails, pwm, level, duty
//          |     |                            | m_tuser: step_ran
//  cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One beat a cycle sustained while m_ does not stall; an input beat goes into the input register,
// then through the step logic into the result register.
// The state update happens as the input register moves into the result register.
// A stall on m_ holds the result; the input register still takes a beat while
// it is empty, so one more beat is buffered before s_tready drops.
// rst is synchronous: state, rails and pwm clear, registers take their defaults.
// cfg_ready is always high; a write shows on cfg in the cycle after cfg_valid.
module tec_rail_and_pwm_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] rail_high_on, [1] rail_low_on, [17:2] pwm_compare,
                                 // [25:18] level_now, [41:26] duty_now, [47:42] zero
  output logic [0:0]  m_tuser,   // [0] step_ran
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tec_seq_pkg::cfg_t    cfg;
  tec_seq_pkg::state_t  state;
  tec_seq_pkg::state_t  state_next;
  tec_seq_pkg::result_t step_res;
  tec_seq_pkg::result_t res;

  logic                             in_valid;
  logic [tec_seq_pkg::ModeW-1:0]    in_mode;
  logic [tec_seq_pkg::ValueW-1:0]   in_value;
  logic                             out_valid;
  logic                             advance;

  assign cfg_ready = 1'b1;

  tec_seq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register free or being emptied this cycle
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode  <= s_tuser;
      in_value <= s_tdata;
    end
  end

  tec_seq_step u_step (
    .cfg   (cfg),
    .cur   (state),
    .mode  (in_mode),
    .value (in_value),
    .nxt   (state_next),
    .res   (step_res)
  );

  // controller state, committed as the beat moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, res.duty_now, res.level_now, res.pwm_compare,
                     res.rail_low_on, res.rail_high_on};
  assign m_tuser  = res.step_ran;

endmodule

// ===== rtl/tec_seq_checker.sv =====
// Port-level checks of the sequencer core, bound to the top level.
module tec_seq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed under stall");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input side never blocks while the output side can move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with output free");

  // an accepted beat reaches the output through the input and result registers when not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("result beat missing after input beat");

endmodule

bind tec_rail_and_pwm_sequencer_core tec_seq_checker u_tec_seq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the thermoelectric rail and PWM sequencer core.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TimeoutCycles = 200000;
  // two-stage pipeline; the tail after draining catches a stray result beat
  localparam int unsigned TailCycles    = 10;
  localparam int unsigned PhaseItems    = 168;
  localparam int unsigned ChunksPerPhase = 4;

  // setting shapes for the random part
  typedef enum int { SET_ALL_LOW, SET_ALL_HIGH, SET_RANDOM } setting_kind_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;    // [15:0] value
  logic [1:0]  s_tuser   = '0;    // [1:0] mode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;           // [0] rail_high_on, [1] rail_low_on, [17:2] pwm_compare,
                                  // [25:18] level_now, [41:26] duty_now, [47:42] zero
  logic [0:0]  m_tuser;           // [0] step_ran
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  tec_rail_and_pwm_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sequencer copy: registers and working state as the block should hold them.
  tec_seq_pkg::cfg_t    seq_cfg;
  tec_seq_pkg::state_t  seq_st;
  tec_seq_pkg::result_t pending_results[$];

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned steps_seen   = 0;
  int unsigned regs_written = 0;

  // Applies one input beat to the sequencer copy and returns the result beat
  // it should produce. Input first, then the period poll, then the step.
  function automatic tec_seq_pkg::result_t advance_sequencer(
    input tec_seq_pkg::mode_t kind,
    input logic [15:0]        v
  );
    tec_seq_pkg::result_t r;
    logic [15:0]          duty_use;
    logic                 ran;
    ran = 1'b0;
    case (kind)
      tec_seq_pkg::MODE_TICK: begin
        // counter saturates at the period
        if (seq_st.period_count < seq_cfg.control_period)
          seq_st.period_count = seq_st.period_count + 16'd1;
      end
      tec_seq_pkg::MODE_LEVEL: seq_st.level_request = v[7:0];
      tec_seq_pkg::MODE_DUTY:  seq_st.duty_request  = v;
      default: ;  // unused mode leaves everything alone
    endcase

    // a period of zero, or one lowered below the count, fires here at once
    if (seq_st.period_count >= seq_cfg.control_period) begin
      ran = 1'b1;
      seq_st.period_count = '0;
      if (seq_st.low_off_count != '0)
        seq_st.low_off_count = seq_st.low_off_count - 8'd1;
      if (seq_st.high_off_count != '0)
        seq_st.high_off_count = seq_st.high_off_count - 8'd1;

      // old duty carries on for a while after a level change
      duty_use = seq_st.duty_request;
      if (seq_st.level_request != seq_st.level_previous && seq_st.hold_count != '0) begin
        seq_st.hold_count = seq_st.hold_count - 16'd1;
        duty_use = seq_st.duty_previous;
      end else begin
        seq_st.hold_count     = seq_cfg.level_hold_steps;
        seq_st.level_previous = seq_st.level_request;
        seq_st.duty_previous  = duty_use;
      end

      // 24 V code wins over the band when the two overlap
      if (seq_st.level_request == seq_cfg.high_level_id) begin
        seq_st.rail_high = 1'b1;
        if (seq_st.low_off_count == '0)
          seq_st.rail_low = 1'b0;
        seq_st.pwm_value      = seq_cfg.pwm_off_value;
        seq_st.high_off_count = seq_cfg.high_to_low_delay;
      end else if (seq_st.level_request >= seq_cfg.band_low_id &&
                   seq_st.level_request <= seq_cfg.band_high_id) begin
        seq_st.rail_low      = 1'b1;
        seq_st.pwm_value     = duty_use;
        seq_st.rail_high     = (seq_st.high_off_count != '0);
        seq_st.low_off_count = seq_cfg.low_to_high_delay;
      end else begin
        // unknown code, or empty band: all off and level forgotten
        seq_st.rail_high     = 1'b0;
        seq_st.rail_low      = 1'b0;
        seq_st.pwm_value     = seq_cfg.pwm_off_value;
        seq_st.level_request = '0;
      end
    end

    r.rail_high_on = seq_st.rail_high;
    r.rail_low_on  = seq_st.rail_low;
    r.pwm_compare  = seq_st.pwm_value;
    r.level_now    = seq_st.level_request;
    r.duty_now     = seq_st.duty_request;
    r.step_ran     = ran;
    return r;
  endfunction

  // Receiver: random back-pressure on the result channel.
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: each result beat against the oldest expectation.
  always @(posedge clk) begin
    tec_seq_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: tdata 0x%0h", m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("rail_high_on", 16'(want.rail_high_on), 16'(m_tdata[0]));
        compare_field("rail_low_on",  16'(want.rail_low_on),  16'(m_tdata[1]));
        compare_field("pwm_compare",  want.pwm_compare,       m_tdata[17:2]);
        compare_field("level_now",    16'(want.level_now),    16'(m_tdata[25:18]));
        compare_field("duty_now",     want.duty_now,          m_tdata[41:26]);
        compare_field("step_ran",     16'(want.step_ran),     16'(m_tuser[0]));
        compare_field("tdata_pad",    16'd0,                  16'(m_tdata[47:42]));
        if (want.step_ran)
          steps_seen++;
      end
    end
  end

  // One input beat, with an optional gap first. tvalid is left high on
  // return so a following beat goes out back to back.
  task automatic send_beat(input tec_seq_pkg::mode_t kind, input logic [15:0] v);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(advance_sequencer(kind, v));
    items_sent++;
  endtask

  // Stops the input stream and waits for every result to come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // One register write; cfg_valid is left high for back-to-back writes.
  task automatic write_reg(input tec_seq_pkg::reg_idx_t idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tec_seq_pkg::REG_CONTROL_PERIOD: seq_cfg.control_period    = d;
      tec_seq_pkg::REG_LEVEL_HOLD:     seq_cfg.level_hold_steps  = d;
      tec_seq_pkg::REG_HIGH_TO_LOW:    seq_cfg.high_to_low_delay = d[7:0];
      tec_seq_pkg::REG_LOW_TO_HIGH:    seq_cfg.low_to_high_delay = d[7:0];
      tec_seq_pkg::REG_PWM_OFF:        seq_cfg.pwm_off_value     = d;
      tec_seq_pkg::REG_HIGH_LEVEL_ID:  seq_cfg.high_level_id     = d[7:0];
      tec_seq_pkg::REG_BAND_LOW_ID:    seq_cfg.band_low_id       = d[7:0];
      tec_seq_pkg::REG_BAND_HIGH_ID:   seq_cfg.band_high_id      = d[7:0];
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic cfg_idle();
    cfg_valid <= 1'b0;
  endtask

  // Writes a whole setting; byte-wide registers get junk in the upper byte.
  task automatic load_setting(input tec_seq_pkg::cfg_t c);
    logic [7:0] junk;
    write_reg(tec_seq_pkg::REG_CONTROL_PERIOD, c.control_period);
    write_reg(tec_seq_pkg::REG_LEVEL_HOLD, c.level_hold_steps);
    junk = 8'($urandom);
    write_reg(tec_seq_pkg::REG_HIGH_TO_LOW, {junk, c.high_to_low_delay});
    junk = 8'($urandom);
    write_reg(tec_seq_pkg::REG_LOW_TO_HIGH, {junk, c.low_to_high_delay});
    write_reg(tec_seq_pkg::REG_PWM_OFF, c.pwm_off_value);
    junk = 8'($urandom);
    write_reg(tec_seq_pkg::REG_HIGH_LEVEL_ID, {junk, c.high_level_id});
    junk = 8'($urandom);
    write_reg(tec_seq_pkg::REG_BAND_LOW_ID, {junk, c.band_low_id});
    junk = 8'($urandom);
    write_reg(tec_seq_pkg::REG_BAND_HIGH_ID, {junk, c.band_high_id});
    cfg_idle();
  endtask

  function automatic tec_seq_pkg::cfg_t make_setting(input setting_kind_t kind);
    tec_seq_pkg::cfg_t c;
    case (kind)
      SET_ALL_LOW:  c = '0;
      SET_ALL_HIGH: c = '1;
      default: begin
        // short periods so steps come often; long holds and delays now and then
        c.control_period = 16'($urandom_range(0, 5));
        if ($urandom_range(5) == 0) begin
          c.level_hold_steps  = 16'hFFFF;
          c.high_to_low_delay = 8'hFF;
          c.low_to_high_delay = 8'hFF;
        end else begin
          c.level_hold_steps  = 16'($urandom_range(0, 8));
          c.high_to_low_delay = 8'($urandom_range(0, 5));
          c.low_to_high_delay = 8'($urandom_range(0, 5));
        end
        c.pwm_off_value = 16'($urandom);
        c.band_low_id   = 8'($urandom_range(0, 40));
        if ($urandom_range(4) == 0)
          c.band_high_id = 8'($urandom);
        else
          c.band_high_id = 8'(c.band_low_id + $urandom_range(0, 30));
        if ($urandom_range(3) == 0)
          c.high_level_id = c.band_low_id;
        else
          c.high_level_id = 8'($urandom);
      end
    endcase
    return c;
  endfunction

  // Random beat: mostly ticks and codes that the current setting knows.
  task automatic send_random_beat();
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  junk;
    pick = $urandom_range(99);
    junk = 8'($urandom);
    if (pick < 45) begin
      send_beat(tec_seq_pkg::MODE_TICK, 16'($urandom));
    end else if (pick < 65) begin
      case ($urandom_range(2))
        0: code = seq_cfg.high_level_id;
        1: begin
          if (seq_cfg.band_low_id <= seq_cfg.band_high_id)
            code = 8'(seq_cfg.band_low_id +
                      $urandom_range(0, seq_cfg.band_high_id - seq_cfg.band_low_id));
          else
            code = 8'($urandom);
        end
        default: code = 8'($urandom);
      endcase
      send_beat(tec_seq_pkg::MODE_LEVEL, {junk, code});
    end else if (pick < 90) begin
      send_beat(tec_seq_pkg::MODE_DUTY, 16'($urandom));
    end else begin
      send_beat(tec_seq_pkg::MODE_UNUSED, 16'($urandom));
    end
  endtask

  // ---- directed tests ----

  // Period zero: a step on every beat. Walks through 24 V mode, the band with
  // the held duty, the unused mode, an unknown code and back to 24 V.
  task automatic test_modes_every_step();
    tec_seq_pkg::cfg_t c;
    wait_idle();
    c.control_period    = 16'd0;
    c.level_hold_steps  = 16'd2;
    c.high_to_low_delay = 8'd2;
    c.low_to_high_delay = 8'd2;
    c.pwm_off_value     = 16'hFFFF;
    c.high_level_id     = 8'd24;
    c.band_low_id       = 8'd5;
    c.band_high_id      = 8'd12;
    load_setting(c);
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'hFF18);   // 24 V, upper byte must be dropped
    send_beat(tec_seq_pkg::MODE_DUTY, 16'hFFFF);
    send_beat(tec_seq_pkg::MODE_TICK, 16'hFFFF);
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'h000C);   // top of band, old duty held
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    send_beat(tec_seq_pkg::MODE_DUTY, 16'h0000);
    send_beat(tec_seq_pkg::MODE_UNUSED, 16'hFFFF);
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'h00FF);   // unknown code clears the level
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'h0005);   // bottom of band
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'h0018);
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
  endtask

  // Count built up under a long period, then the period dropped below it.
  task automatic test_period_lowered();
    wait_idle();
    write_reg(tec_seq_pkg::REG_CONTROL_PERIOD, 16'd100);
    write_reg(tec_seq_pkg::REG_LEVEL_HOLD, 16'd0);
    cfg_idle();
    repeat (4) send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    wait_idle();
    write_reg(tec_seq_pkg::REG_CONTROL_PERIOD, 16'd2);
    cfg_idle();
    send_beat(tec_seq_pkg::MODE_UNUSED, 16'h0000);  // step fires on the next beat of any kind
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
  endtask

  // 24 V code inside the band, then a band with low above high.
  task automatic test_overlap_and_empty_band();
    wait_idle();
    write_reg(tec_seq_pkg::REG_CONTROL_PERIOD, 16'd1);
    write_reg(tec_seq_pkg::REG_HIGH_LEVEL_ID, 16'h0007);
    write_reg(tec_seq_pkg::REG_BAND_LOW_ID, 16'h0005);
    write_reg(tec_seq_pkg::REG_BAND_HIGH_ID, 16'h000C);
    cfg_idle();
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'h0007);
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    wait_idle();
    write_reg(tec_seq_pkg::REG_BAND_LOW_ID, 16'd200);
    write_reg(tec_seq_pkg::REG_BAND_HIGH_ID, 16'd100);
    cfg_idle();
    send_beat(tec_seq_pkg::MODE_LEVEL, 16'h0096);
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
    send_beat(tec_seq_pkg::MODE_TICK, 16'h0000);
  endtask

  // ---- random test ----

  // Several settings per phase, each loaded with the block drained.
  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input bit low_first, input bit high_last);
    setting_kind_t kind;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int unsigned ch = 0; ch < ChunksPerPhase; ch++) begin
      if (low_first && ch == 0)
        kind = SET_ALL_LOW;
      else if (high_last && ch == ChunksPerPhase - 1)
        kind = SET_ALL_HIGH;
      else
        kind = SET_RANDOM;
      wait_idle();
      load_setting(make_setting(kind));
      repeat (PhaseItems / ChunksPerPhase) send_random_beat();
    end
  endtask

  // Watchdog.
  initial begin
    repeat (TimeoutCycles) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    seq_cfg.control_period    = tec_seq_pkg::RstControlPeriod;
    seq_cfg.level_hold_steps  = tec_seq_pkg::RstLevelHold;
    seq_cfg.high_to_low_delay = tec_seq_pkg::RstHighToLow;
    seq_cfg.low_to_high_delay = tec_seq_pkg::RstLowToHigh;
    seq_cfg.pwm_off_value     = tec_seq_pkg::RstPwmOff;
    seq_cfg.high_level_id     = tec_seq_pkg::RstHighLevelId;
    seq_cfg.band_low_id       = tec_seq_pkg::RstBandLowId;
    seq_cfg.band_high_id      = tec_seq_pkg::RstBandHighId;
    seq_st = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_modes_every_step();
    test_period_lowered();
    test_overlap_and_empty_band();
    test_random_phase(7, 57, 1'b1, 1'b0);
    test_random_phase(57, 7, 1'b0, 1'b0);
    test_random_phase(0, 0, 1'b0, 1'b1);

    wait_idle();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d input beats with %0d control steps and %0d register writes,",
             items_sent, steps_seen, regs_written);
    $display("under directed cases and three back-pressure mixes; %0d mismatches.",
             mismatches);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tec_seq_pkg.sv
rtl/tec_seq_cfg.sv
rtl/tec_seq_step.sv
rtl/tec_rail_and_pwm_sequencer_core.sv
rtl/tec_seq_checker.sv
tb/testbench.sv
